// File: sv/thar_pkg.sv
// Package for the touch hotspot auto-repeat block.
// Widths, reset values, request and register codes, and the structs passed between modules.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package thar_pkg;

    // fixed field widths
    localparam int RAW_W     = 12;
    localparam int PIX_W     = 10;
    localparam int CNT_W     = 8;
    localparam int REL_W     = 11;
    localparam int SLOT_W    = 6;   // enough for up to 64 hotspots
    localparam int NUM_W     = 24;  // 2*d*size + span
    localparam int DEN_W     = 13;  // 2*span
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DAT_W = 12;
    localparam int OUT_IDX_W = 4;

    // defaults for the top-level parameters
    localparam int HOTSPOTS_DEF      = 16;
    localparam int SCREEN_WIDTH_DEF  = 600;
    localparam int SCREEN_HEIGHT_DEF = 448;

    // register reset values
    localparam logic [RAW_W-1:0] PMIN_RST   = 12'd30;
    localparam logic [CNT_W-1:0] HOLD_RST   = 8'd45;
    localparam logic [CNT_W-1:0] REPEAT_RST = 8'd10;
    localparam logic [RAW_W-1:0] LEFT_RST   = 12'd190;
    localparam logic [RAW_W-1:0] RIGHT_RST  = 12'd3915;
    localparam logic [RAW_W-1:0] BOTTOM_RST = 12'd375;
    localparam logic [RAW_W-1:0] TOP_RST    = 12'd3880;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_PMIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEFT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RIGHT  = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BOTTOM = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP    = 3'd6;

    // request codes
    typedef enum logic [1:0] {
        REQ_TICK  = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_CLEAR = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    // table write broadcast to every cell
    typedef struct packed {
        logic              wr;
        logic              clr;
        logic [SLOT_W-1:0] idx;
        logic              vld;
        logic [PIX_W-1:0]  x;
        logic [PIX_W-1:0]  y;
        logic [PIX_W-1:0]  w;
        logic [PIX_W-1:0]  h;
    } t_tbl_wr;

    // probe walking down the cell chain
    typedef struct packed {
        logic              vld;
        logic [PIX_W-1:0]  px;
        logic [PIX_W-1:0]  py;
        logic [SLOT_W-1:0] tgt;
        logic              hit;
        logic [SLOT_W-1:0] hit_idx;
        logic [PIX_W-1:0]  hit_x;
        logic [PIX_W-1:0]  hit_y;
        logic [PIX_W-1:0]  tgt_x;
        logic [PIX_W-1:0]  tgt_y;
    } t_probe;

endpackage

`default_nettype wire

// File: sv/thar_div.sv
// Restoring divider, one quotient bit per cycle, for the pixel mapping.
// Depends on thar_pkg; the quotient is known to fit PIX_W bits.
`timescale 1ns / 1ps
`default_nettype none

module thar_div
    import thar_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_go,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [PIX_W-1:0]      o_quo
);

    localparam int CW = $clog2(PIX_W + 1);

    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [PIX_W-1:0] r_low;
    logic [PIX_W-1:0] r_quo;
    logic [CW-1:0]    r_cnt;
    logic             r_run;
    logic             r_done;

    logic [DEN_W:0]   w_rem2;
    logic             w_ge;
    logic [DEN_W-1:0] w_rem_n;

    // one restoring step
    always_comb begin
        w_rem2  = {r_rem, r_low[PIX_W-1]};
        w_ge    = (w_rem2 >= {1'b0, r_den});
        w_rem_n = w_ge ? DEN_W'(w_rem2 - {1'b0, r_den}) : w_rem2[DEN_W-1:0];
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_go) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= CW'(r_cnt + 1'b1);
                if (r_cnt == CW'(PIX_W - 1)) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath: upper numerator bits are already below the divisor
    always_ff @(posedge i_clk) begin
        if (i_go) begin
            r_rem <= i_num[NUM_W-2 -: DEN_W];
            r_low <= i_num[PIX_W-1:0];
            r_den <= i_den;
            r_quo <= '0;
        end else if (r_run) begin
            r_rem <= w_rem_n;
            r_low <= {r_low[PIX_W-2:0], 1'b0};
            r_quo <= {r_quo[PIX_W-2:0], w_ge};
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

`default_nettype wire

// File: sv/thar_cell.sv
// One hotspot table cell: holds an entry and tests the passing probe against it.
// Depends on thar_pkg; cells are chained in the top level.
`timescale 1ns / 1ps
`default_nettype none

module thar_cell
    import thar_pkg::*;
#(
    parameter int CELL_IDX = 0
) (
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire t_tbl_wr i_wr,
    input  wire t_probe  i_probe,
    output t_probe       o_probe
);

    localparam logic [SLOT_W-1:0] MY_IDX = SLOT_W'(CELL_IDX);

    logic             r_vld;
    logic [PIX_W-1:0] r_x, r_y, r_w, r_h;
    t_probe           r_probe;
    t_probe           n_probe;
    logic             w_hit;

    // entry storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_wr.clr) begin
            r_vld <= 1'b0;
        end else if (i_wr.wr && i_wr.idx == MY_IDX) begin
            r_vld <= i_wr.vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.clr) begin
            r_x <= '0;
            r_y <= '0;
            r_w <= '0;
            r_h <= '0;
        end else if (i_wr.wr && i_wr.idx == MY_IDX) begin
            r_x <= i_wr.x;
            r_y <= i_wr.y;
            r_w <= i_wr.w;
            r_h <= i_wr.h;
        end
    end

    // strict bounds test, first hit along the chain wins
    always_comb begin
        w_hit = r_vld
             && (i_probe.px > r_x)
             && ({1'b0, i_probe.px} < ({1'b0, r_x} + {1'b0, r_w}))
             && (i_probe.py > r_y)
             && ({1'b0, i_probe.py} < ({1'b0, r_y} + {1'b0, r_h}));
        n_probe = i_probe;
        if (!i_probe.hit && w_hit) begin
            n_probe.hit     = 1'b1;
            n_probe.hit_idx = MY_IDX;
            n_probe.hit_x   = r_x;
            n_probe.hit_y   = r_y;
        end
        if (i_probe.tgt == MY_IDX) begin
            n_probe.tgt_x = r_x;
            n_probe.tgt_y = r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_probe <= '0;
        end else begin
            r_probe <= n_probe;
        end
    end

    assign o_probe = r_probe;

endmodule

`default_nettype wire

// File: sv/touch_hotspot_auto_repeat_unit.sv
// Top level of the touch hotspot auto-repeat block: registers, timing, mapping, cell chain.
// Depends on thar_pkg, thar_div and thar_cell.
//
// Items are taken on i_start while o_busy is low; each gives exactly one result, shown for one
// cycle with o_valid, which the receiver must take. Table writes, clears, unknown requests,
// releases and ticks that miss the hold/repeat timing answer in the next cycle. A tick that
// may fire maps both axes through two bit-serial dividers and then sends a probe down the
// chain of HOTSPOTS cells, one cell per cycle. Configuration writes are always ready.
`timescale 1ns / 1ps
`default_nettype none

module touch_hotspot_auto_repeat_unit
    import thar_pkg::*;
#(
    parameter int HOTSPOTS      = HOTSPOTS_DEF,
    parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_start,
    output logic                      o_busy,
    input  wire logic [1:0]           i_req_type,
    input  wire logic [RAW_W-1:0]     i_raw_x,
    input  wire logic [RAW_W-1:0]     i_raw_y,
    input  wire logic [RAW_W-1:0]     i_pressure,
    input  wire logic [3:0]           i_entry_index,
    input  wire logic                 i_entry_valid,
    input  wire logic [PIX_W-1:0]     i_entry_x,
    input  wire logic [PIX_W-1:0]     i_entry_y,
    input  wire logic [PIX_W-1:0]     i_entry_width,
    input  wire logic [PIX_W-1:0]     i_entry_height,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_DAT_W-1:0] i_cfg_data,
    output logic                      o_valid,
    output logic                      o_fire,
    output logic [OUT_IDX_W-1:0]      o_hotspot_index,
    output logic signed [REL_W-1:0]   o_rel_x,
    output logic signed [REL_W-1:0]   o_rel_y,
    output logic signed [REL_W-1:0]   o_rel_last_x,
    output logic signed [REL_W-1:0]   o_rel_last_y,
    output logic                      o_first_press,
    output logic                      o_touch_down
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_MAP,
        S_DIV,
        S_SCAN
    } t_state;

    // configuration registers
    logic [RAW_W-1:0] r_pmin, r_left, r_right, r_bottom, r_top;
    logic [CNT_W-1:0] r_hold, r_repeat;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pmin   <= PMIN_RST;
            r_hold   <= HOLD_RST;
            r_repeat <= REPEAT_RST;
            r_left   <= LEFT_RST;
            r_right  <= RIGHT_RST;
            r_bottom <= BOTTOM_RST;
            r_top    <= TOP_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_PMIN:   r_pmin   <= i_cfg_data;
                CFG_HOLD:   r_hold   <= i_cfg_data[CNT_W-1:0];
                CFG_REPEAT: r_repeat <= i_cfg_data[CNT_W-1:0];
                CFG_LEFT:   r_left   <= i_cfg_data;
                CFG_RIGHT:  r_right  <= i_cfg_data;
                CFG_BOTTOM: r_bottom <= i_cfg_data;
                CFG_TOP:    r_top    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // block state
    t_state            r_state;
    logic              r_released;
    logic              r_pressed_vld;
    logic [SLOT_W-1:0] r_pressed_slot;
    logic [CNT_W-1:0]  r_held, r_since;
    logic [PIX_W-1:0]  r_last_x, r_last_y;
    logic [RAW_W-1:0]  r_rx, r_ry;
    logic [PIX_W-1:0]  r_px, r_py;
    logic [NUM_W-1:0]  r_numx, r_numy;
    logic [DEN_W-1:0]  r_denx, r_deny;
    logic              r_zx, r_zy;
    logic              r_div_go;
    t_probe            r_probe_in;

    logic w_accept;
    assign w_accept = i_start && (r_state == S_IDLE);
    assign o_busy   = (r_state != S_IDLE);

    // saturating counters and timing check at accept
    logic [CNT_W-1:0] w_held_inc, w_since_inc;
    logic             w_release, w_timing;

    always_comb begin
        w_held_inc  = (r_held  == CNT_MAX) ? r_held  : CNT_W'(r_held  + 1'b1);
        w_since_inc = (r_since == CNT_MAX) ? r_since : CNT_W'(r_since + 1'b1);
        w_release   = (i_raw_x == '0) || (i_raw_y == '0) || (i_pressure < r_pmin);
        w_timing    = (r_released || w_held_inc == CNT_MAX || w_held_inc > r_hold)
                   && (w_since_inc == CNT_MAX || w_since_inc > r_repeat);
    end

    // clamp to the window and form numerator and divisor (Y flipped)
    logic [RAW_W-1:0] w_xc, w_yc, w_dx, w_dy, w_spx, w_spy;
    logic [NUM_W-1:0] w_numx, w_numy;

    always_comb begin
        w_xc   = (r_rx < r_left) ? r_left : ((r_rx > r_right) ? r_right : r_rx);
        w_yc   = (r_ry < r_bottom) ? r_bottom : ((r_ry > r_top) ? r_top : r_ry);
        w_spx  = RAW_W'(r_right - r_left);
        w_spy  = RAW_W'(r_top - r_bottom);
        w_dx   = RAW_W'(w_xc - r_left);
        w_dy   = RAW_W'(r_top - w_yc);
        w_numx = NUM_W'((NUM_W'(w_dx) * NUM_W'(SCREEN_WIDTH)) << 1) + NUM_W'(w_spx);
        w_numy = NUM_W'((NUM_W'(w_dy) * NUM_W'(SCREEN_HEIGHT)) << 1) + NUM_W'(w_spy);
    end

    // dividers
    logic             w_dx_done, w_dy_done;
    logic [PIX_W-1:0] w_qx, w_qy;

    thar_div u_div_x (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (r_numx),
        .i_den   (r_denx),
        .o_done  (w_dx_done),
        .o_quo   (w_qx)
    );

    thar_div u_div_y (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_go    (r_div_go),
        .i_num   (r_numy),
        .i_den   (r_deny),
        .o_done  (w_dy_done),
        .o_quo   (w_qy)
    );

    // table write broadcast
    t_tbl_wr w_wr;

    always_comb begin
        w_wr.wr  = w_accept && (i_req_type == REQ_WRITE);
        w_wr.clr = w_accept && (i_req_type == REQ_CLEAR);
        w_wr.idx = SLOT_W'(i_entry_index);
        w_wr.vld = i_entry_valid;
        w_wr.x   = i_entry_x;
        w_wr.y   = i_entry_y;
        w_wr.w   = i_entry_width;
        w_wr.h   = i_entry_height;
    end

    // cell chain
    t_probe w_probe [HOTSPOTS+1];

    assign w_probe[0] = r_probe_in;

    for (genvar g = 0; g < HOTSPOTS; g++) begin : g_cell
        thar_cell #(
            .CELL_IDX (g)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_wr    (w_wr),
            .i_probe (w_probe[g]),
            .o_probe (w_probe[g+1])
        );
    end

    // action decision at the end of the chain
    t_probe            w_end;
    logic              w_fire;
    logic [SLOT_W-1:0] w_slot;
    logic [PIX_W-1:0]  w_ex, w_ey;

    always_comb begin
        w_end = w_probe[HOTSPOTS];
        if (r_released) begin
            w_fire = w_end.hit;
            w_slot = w_end.hit_idx;
            w_ex   = w_end.hit_x;
            w_ey   = w_end.hit_y;
        end else begin
            w_fire = r_pressed_vld;
            w_slot = r_pressed_slot;
            w_ex   = w_end.tgt_x;
            w_ey   = w_end.tgt_y;
        end
    end

    // sequencer, state and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_released     <= 1'b1;
            r_pressed_vld  <= 1'b0;
            r_pressed_slot <= '0;
            r_held         <= CNT_MAX;
            r_since        <= CNT_MAX;
            r_last_x       <= '0;
            r_last_y       <= '0;
            r_div_go       <= 1'b0;
            r_probe_in     <= '0;
            o_valid        <= 1'b0;
        end else begin
            o_valid        <= 1'b0;
            r_div_go       <= 1'b0;
            r_probe_in.vld <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        o_fire          <= 1'b0;
                        o_hotspot_index <= '0;
                        o_rel_x         <= '0;
                        o_rel_y         <= '0;
                        o_rel_last_x    <= '0;
                        o_rel_last_y    <= '0;
                        o_first_press   <= 1'b0;
                        o_touch_down    <= 1'b0;
                        r_rx            <= i_raw_x;
                        r_ry            <= i_raw_y;
                        if (i_req_type == REQ_TICK) begin
                            r_held  <= w_held_inc;
                            r_since <= w_since_inc;
                            if (w_release) begin
                                r_released    <= 1'b1;
                                r_pressed_vld <= 1'b0;
                                o_valid       <= 1'b1;
                            end else if (!w_timing) begin
                                o_touch_down <= 1'b1;
                                o_valid      <= 1'b1;
                            end else begin
                                r_state <= S_MAP;
                            end
                        end else begin
                            o_valid <= 1'b1;
                        end
                    end
                end
                S_MAP: begin
                    r_numx   <= w_numx;
                    r_numy   <= w_numy;
                    r_denx   <= {w_spx, 1'b0};
                    r_deny   <= {w_spy, 1'b0};
                    r_zx     <= (r_right <= r_left);
                    r_zy     <= (r_top <= r_bottom);
                    r_div_go <= 1'b1;
                    r_state  <= S_DIV;
                end
                S_DIV: begin
                    if (w_dx_done && w_dy_done) begin
                        r_px           <= r_zx ? '0 : w_qx;
                        r_py           <= r_zy ? '0 : w_qy;
                        r_probe_in     <= '0;
                        r_probe_in.vld <= 1'b1;
                        r_probe_in.px  <= r_zx ? '0 : w_qx;
                        r_probe_in.py  <= r_zy ? '0 : w_qy;
                        r_probe_in.tgt <= r_pressed_slot;
                        r_state        <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (w_end.vld) begin
                        o_valid      <= 1'b1;
                        o_touch_down <= 1'b1;
                        r_state      <= S_IDLE;
                        if (w_fire) begin
                            o_fire          <= 1'b1;
                            o_hotspot_index <= w_slot[OUT_IDX_W-1:0];
                            o_rel_x         <= REL_W'({1'b0, r_px} - {1'b0, w_ex});
                            o_rel_y         <= REL_W'({1'b0, r_py} - {1'b0, w_ey});
                            o_rel_last_x    <= REL_W'({1'b0, r_last_x} - {1'b0, w_ex});
                            o_rel_last_y    <= REL_W'({1'b0, r_last_y} - {1'b0, w_ey});
                            o_first_press   <= r_released;
                            if (r_released) begin
                                r_pressed_vld  <= 1'b1;
                                r_pressed_slot <= w_slot;
                                r_held         <= '0;
                            end
                            r_since    <= '0;
                            r_released <= 1'b0;
                            r_last_x   <= r_px;
                            r_last_y   <= r_py;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // checks
    a_fire_needs_touch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_fire) |-> o_touch_down)
        else $error("action issued without a valid touch");

    a_quiet_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_fire) |-> (o_hotspot_index == '0 && o_rel_x == '0 && o_rel_y == '0
            && o_first_press == 1'b0))
        else $error("non-firing result carries action fields");

    a_scan_needs_divide: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_probe_in.vld |-> $past(r_state == S_DIV))
        else $error("probe launched without a finished mapping");

    a_press_tracks_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_released |-> r_pressed_vld)
        else $error("held touch without a pressed hotspot");

endmodule

`default_nettype wire

// File: tb/tb.sv
// Testbench for the touch hotspot auto-repeat unit: table writes, touch ticks, calibration.
// Depends on thar_pkg and touch_hotspot_auto_repeat_unit; predicts every result itself.
`timescale 1ns / 1ps

module tb;
    import thar_pkg::*;

    localparam int NSPOT = 16;
    localparam int SCR_W = 600;
    localparam int SCR_H = 448;
    localparam int WATCHDOG = 20000;

    typedef struct packed {
        logic                    fire;
        logic [3:0]              idx;
        logic [REL_W-1:0]        rx;
        logic [REL_W-1:0]        ry;
        logic [REL_W-1:0]        rlx;
        logic [REL_W-1:0]        rly;
        logic                    first;
        logic                    down;
    } t_action;

    typedef struct {
        bit        vld;
        bit [9:0]  x, y, w, h;
    } t_spot;

    logic clk = 0;
    logic rst_n = 0;
    logic start = 0;
    logic busy;
    logic [1:0] req_type = '0;
    logic [RAW_W-1:0] raw_x = '0, raw_y = '0, pressure = '0;
    logic [3:0] e_idx = '0;
    logic e_vld = 0;
    logic [PIX_W-1:0] e_x = '0, e_y = '0, e_w = '0, e_h = '0;
    logic cfg_valid = 0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_DAT_W-1:0] cfg_data = '0;
    logic o_valid, o_fire, o_first, o_down;
    logic [3:0] o_idx;
    logic signed [REL_W-1:0] o_rx, o_ry, o_rlx, o_rly;

    touch_hotspot_auto_repeat_unit u_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_req_type(req_type), .i_raw_x(raw_x), .i_raw_y(raw_y), .i_pressure(pressure),
        .i_entry_index(e_idx), .i_entry_valid(e_vld), .i_entry_x(e_x), .i_entry_y(e_y),
        .i_entry_width(e_w), .i_entry_height(e_h),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index),
        .i_cfg_data(cfg_data),
        .o_valid(o_valid), .o_fire(o_fire), .o_hotspot_index(o_idx), .o_rel_x(o_rx),
        .o_rel_y(o_ry), .o_rel_last_x(o_rlx), .o_rel_last_y(o_rly),
        .o_first_press(o_first), .o_touch_down(o_down)
    );

    initial begin
        forever #4 clk = ~clk;
    end

    // predictor state
    bit [11:0] m_pmin, m_left, m_right, m_bottom, m_top;
    bit [7:0]  m_hold, m_repeat, m_held, m_since;
    t_spot     m_table [NSPOT];
    bit        m_released, m_pvld;
    int        m_pslot;
    bit [9:0]  m_last_x, m_last_y;

    t_action expected_actions[$];
    int errors = 0;
    int results_seen = 0;
    int fires_seen = 0;
    int idle_pct = 0;
    int idle_cycles = 0;

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp);
        errors++;
        $display("MISMATCH %s: got %0d expected %0d at %0t", what, got, exp, $realtime);
    endtask

    function automatic bit [9:0] map_pixel(input bit [11:0] v, input bit [11:0] lo,
                                           input bit [11:0] hi, input int size,
                                           input bit flip);
        longint d, span, vv;
        if (hi <= lo) return 0;
        vv = v;
        if (vv < lo) vv = lo;
        if (vv > hi) vv = hi;
        span = hi - lo;
        d = flip ? (hi - vv) : (vv - lo);
        return 10'((2 * d * size + span) / (2 * span));
    endfunction

    function automatic bit counter_passed(input bit [7:0] cnt, input bit [7:0] lim);
        return cnt == 8'hFF || cnt > lim;
    endfunction

    task automatic predictor_reset();
        m_pmin = PMIN_RST; m_hold = HOLD_RST; m_repeat = REPEAT_RST;
        m_left = LEFT_RST; m_right = RIGHT_RST; m_bottom = BOTTOM_RST; m_top = TOP_RST;
        foreach (m_table[i]) m_table[i] = '{0, 0, 0, 0, 0};
        m_released = 1; m_pvld = 0; m_pslot = 0;
        m_held = 8'hFF; m_since = 8'hFF; m_last_x = 0; m_last_y = 0;
    endtask

    // one accepted item -> one expected action record
    function automatic t_action predict_action(input t_req req, input bit [11:0] rx,
            input bit [11:0] ry, input bit [11:0] pr, input bit [3:0] ei, input bit ev,
            input bit [9:0] ex, input bit [9:0] ey, input bit [9:0] ew, input bit [9:0] eh);
        t_action a;
        bit [9:0] px, py;
        bit hit;
        int hidx, s;
        a = '0;
        hit = 0;
        hidx = 0;
        case (req)
            REQ_WRITE: begin
                m_table[ei] = '{ev, ex, ey, ew, eh};
                return a;
            end
            REQ_CLEAR: begin
                foreach (m_table[i]) m_table[i] = '{0, 0, 0, 0, 0};
                return a;
            end
            REQ_TICK: ;
            default: return a;
        endcase
        if (m_held != 8'hFF) m_held++;
        if (m_since != 8'hFF) m_since++;
        if (rx == 0 || ry == 0 || pr < m_pmin) begin
            m_released = 1;
            m_pvld = 0;
            return a;
        end
        a.down = 1;
        px = map_pixel(rx, m_left, m_right, SCR_W, 0);
        py = map_pixel(ry, m_bottom, m_top, SCR_H, 1);
        if (!((m_released || counter_passed(m_held, m_hold))
              && counter_passed(m_since, m_repeat)))
            return a;
        for (int i = 0; i < NSPOT; i++) begin
            if (!hit && m_table[i].vld && px > m_table[i].x
                && 11'(px) < 11'(m_table[i].x) + 11'(m_table[i].w)
                && py > m_table[i].y
                && 11'(py) < 11'(m_table[i].y) + 11'(m_table[i].h)) begin
                hit = 1;
                hidx = i;
            end
        end
        if (m_released) begin
            if (!hit) return a;
            m_pvld = 1;
            m_pslot = hidx;
            m_held = 0;
        end else if (!m_pvld) begin
            return a;
        end
        s = m_pslot;
        a.fire = 1;
        a.idx = 4'(s);
        a.rx = 11'(px) - 11'(m_table[s].x);
        a.ry = 11'(py) - 11'(m_table[s].y);
        a.rlx = 11'(m_last_x) - 11'(m_table[s].x);
        a.rly = 11'(m_last_y) - 11'(m_table[s].y);
        a.first = m_released;
        m_since = 0;
        m_released = 0;
        m_last_x = px;
        m_last_y = py;
        return a;
    endfunction

    // result checker
    always @(posedge clk) begin
        if (rst_n && o_valid) begin
            t_action e;
            results_seen++;
            if (expected_actions.size() == 0) begin
                report("unexpected result", 1, 0);
            end else begin
                e = expected_actions.pop_front();
                if (o_fire) fires_seen++;
                if (o_fire !== e.fire) report("fire", o_fire, e.fire);
                if (o_idx !== e.idx) report("hotspot_index", o_idx, e.idx);
                if (o_rx !== e.rx) report("rel_x", o_rx, e.rx);
                if (o_ry !== e.ry) report("rel_y", o_ry, e.ry);
                if (o_rlx !== e.rlx) report("rel_last_x", o_rlx, e.rlx);
                if (o_rly !== e.rly) report("rel_last_y", o_rly, e.rly);
                if (o_first !== e.first) report("first_press", o_first, e.first);
                if (o_down !== e.down) report("touch_down", o_down, e.down);
            end
        end
    end

    // watchdog on cycles with nothing accepted
    always @(posedge clk) begin
        if ((start && !busy) || o_valid || (cfg_valid && cfg_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG) begin
            $display("watchdog expired");
            $display("tb failed");
            $finish;
        end
    end

    // start stays high between back-to-back items; idle gaps and drains drop it
    task automatic send_item(input t_req req, input bit [11:0] rx, input bit [11:0] ry,
            input bit [11:0] pr, input bit [3:0] ei, input bit ev, input bit [9:0] ex,
            input bit [9:0] ey, input bit [9:0] ew, input bit [9:0] eh);
        while ($urandom_range(99) < idle_pct) begin
            start <= 0;
            @(posedge clk);
        end
        req_type <= req; raw_x <= rx; raw_y <= ry; pressure <= pr;
        e_idx <= ei; e_vld <= ev; e_x <= ex; e_y <= ey; e_w <= ew; e_h <= eh;
        start <= 1;
        @(posedge clk);
        while (busy) @(posedge clk);
        expected_actions.push_back(predict_action(req, rx, ry, pr, ei, ev, ex, ey, ew, eh));
    endtask

    task automatic tick(input bit [11:0] rx, input bit [11:0] ry, input bit [11:0] pr);
        send_item(REQ_TICK, rx, ry, pr, 0, 0, 0, 0, 0, 0);
    endtask

    task automatic put_spot(input bit [3:0] ei, input bit ev, input bit [9:0] ex,
                            input bit [9:0] ey, input bit [9:0] ew, input bit [9:0] eh);
        send_item(REQ_WRITE, 0, 0, 0, ei, ev, ex, ey, ew, eh);
    endtask

    // drain, let the block settle, then write a register
    task automatic wait_drained();
        start <= 0;
        while (expected_actions.size() != 0) @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input bit [11:0] val);
        wait_drained();
        cfg_index <= idx; cfg_data <= val; cfg_valid <= 1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        cfg_valid <= 0;
        case (idx)
            CFG_PMIN:   m_pmin = val;
            CFG_HOLD:   m_hold = val[7:0];
            CFG_REPEAT: m_repeat = val[7:0];
            CFG_LEFT:   m_left = val;
            CFG_RIGHT:  m_right = val;
            CFG_BOTTOM: m_bottom = val;
            CFG_TOP:    m_top = val;
            default: ;
        endcase
    endtask

    task automatic set_timing(input bit [11:0] pm, input bit [7:0] hd, input bit [7:0] rp);
        write_reg(CFG_PMIN, pm);
        write_reg(CFG_HOLD, hd);
        write_reg(CFG_REPEAT, rp);
    endtask

    task automatic set_cal(input bit [11:0] l, input bit [11:0] r, input bit [11:0] b,
                           input bit [11:0] t);
        write_reg(CFG_LEFT, l);
        write_reg(CFG_RIGHT, r);
        write_reg(CFG_BOTTOM, b);
        write_reg(CFG_TOP, t);
    endtask

    // directed: table ops, edge values, release, clamping, odd requests
    task automatic test_directed();
        set_timing(30, 2, 1);
        put_spot(0, 1, 0, 0, 1023, 1023);
        put_spot(1, 1, 100, 100, 200, 200);
        put_spot(15, 0, 1023, 1023, 1023, 1023);
        tick(2000, 2000, 4095);
        tick(2000, 2000, 4095);
        tick(2000, 2000, 4095);
        tick(2000, 2000, 4095);
        put_spot(0, 1, 5, 7, 3, 3);
        tick(4095, 4095, 4095);
        tick(4095, 4095, 4095);
        tick(0, 2000, 4095);
        tick(2000, 0, 4095);
        tick(2000, 2000, 29);
        tick(1, 1, 4095);
        tick(2000, 2000, 30);
        send_item(REQ_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        tick(2000, 2000, 4095);
        send_item(REQ_NONE, 4095, 4095, 4095, 15, 1, 1023, 1023, 1023, 1023);
        put_spot(2, 1, 0, 0, 700, 500);
        tick(2000, 2000, 0);
        tick(2000, 2000, 4095);
        write_reg(3'd7, 12'hFFF);
        set_cal(4095, 0, 4095, 0);
        tick(100, 100, 4095);
        tick(3000, 3000, 4095);
        set_cal(190, 3915, 375, 3880);
    endtask

    // random: press sequences over a random table, some noise
    task automatic test_random(input int n, input int pct);
        int k;
        bit [11:0] bx, by;
        idle_pct = pct;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(99);
            if (k < 8) begin
                put_spot(4'($urandom_range(15)), $urandom_range(99) < 85,
                         10'($urandom_range(500)), 10'($urandom_range(400)),
                         10'($urandom_range(1023)), 10'($urandom_range(1023)));
            end else if (k < 10) begin
                send_item(t_req'($urandom_range(3)), 12'($urandom), 12'($urandom),
                          12'($urandom), 4'($urandom), 1'($urandom), 10'($urandom),
                          10'($urandom), 10'($urandom), 10'($urandom));
            end else begin
                bx = 12'($urandom_range(4095));
                by = 12'($urandom_range(4095));
                repeat ($urandom_range(12, 1)) begin
                    if ($urandom_range(9) == 0) tick(12'($urandom), 12'($urandom), 0);
                    else tick(bx ^ 12'($urandom_range(7)), by ^ 12'($urandom_range(7)),
                              12'($urandom_range(4095, 20)));
                    i++;
                end
            end
        end
        idle_pct = 0;
    endtask

    initial begin
        predictor_reset();
        repeat (4) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);
        test_directed();
        test_random(130, 0);
        wait_drained();
        set_timing(0, 0, 0);
        test_random(130, 45);
        wait_drained();
        set_timing(4095, 255, 255);
        set_cal(0, 4095, 0, 4095);
        test_random(60, 14);
        wait_drained();
        set_timing(200, 4, 3);
        set_cal(1000, 3000, 800, 2500);
        test_random(130, 45);
        wait_drained();
        test_random(40, 0);
        wait_drained();
        $display("Covered table writes and clears, releases, calibration extremes and auto-repeat");
        $display("timing: %0d results checked, %0d of them firing.", results_seen, fires_seen);
        if (errors == 0) $display("tb passed");
        else $display("tb failed");
        $finish;
    end
endmodule
